// ===== design/spaq_pkg.sv =====
// spaq_pkg: shared types and constants for the sorted-array priority queue
// used by spaq_cell, the top level and the checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spaq_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned LIMIT_W = 7;
    localparam int unsigned OCC_W   = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pri;
        logic signed [DATA_W-1:0] val;
    } entry_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic   load;
        logic   enq;
        entry_t new_entry;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/spaq_cell.sv =====
// spaq_cell: one slot of the sorted chain, holds an entry and picks its
// next entry from itself, the new item or a neighbor; uses spaq_pkg
`timescale 1ns / 1ps
`default_nettype none

module spaq_cell (
    input  wire logic                clk,
    input  wire spaq_pkg::cell_ctl_t ctl,
    input  wire logic                occupied,
    input  wire logic                left_keep,
    input  wire spaq_pkg::entry_t    left_entry,
    input  wire spaq_pkg::entry_t    right_entry,
    output logic                     keep,
    output spaq_pkg::entry_t         entry
);
    import spaq_pkg::*;

    entry_t slot_reg;
    entry_t slot_next;

    // held entry stays ahead of a new one of equal or greater priority
    assign keep = occupied && (slot_reg.pri <= ctl.new_entry.pri);

    always_comb
    begin
        if (!ctl.enq)
        begin
            slot_next = right_entry;
        end
        else if (keep)
        begin
            slot_next = slot_reg;
        end
        else if (left_keep)
        begin
            slot_next = ctl.new_entry;
        end
        else
        begin
            slot_next = left_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            slot_reg <= slot_next;
        end
    end

    assign entry = slot_reg;

endmodule

`default_nettype wire

// ===== design/sorted_array_priority_queue_top.sv =====
// sorted_array_priority_queue_top: chain of spaq_cell slots, count, limit
// register and output register; uses spaq_pkg and spaq_cell
//
//   channel   direction   signals                                   item
//   input     in          in_valid in_ready func value priority_req  one operation
//   output    out         out_valid out_ready status removed_value   one result
//                         removed_priority occupancy
//   config    in          cfg_valid cfg_ready cfg_data              capacity limit
//
// one item per cycle while in_ready is high: every cell compares its priority
// with the new one in parallel and all cells shift or hold in the same clock edge
// the result is registered at the edge that takes the item and is offered
// from the next cycle on
// a new item is taken while out_ready is low only if the output register is empty
// reset clears the count, the output valid and loads the limit with 64; slot
// contents are not cleared since slots at or above the count are never read
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_priority_queue_top #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // operation items
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           func,
    input  wire logic signed [31:0]             value,
    input  wire logic signed [31:0]             priority_req,
    // result items
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [1:0]                          status,
    output logic signed [31:0]                  removed_value,
    output logic signed [31:0]                  removed_priority,
    output logic [6:0]                          occupancy,
    // capacity limit write
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [6:0]                     cfg_data
);
    import spaq_pkg::*;

    // count width holds CAPACITY itself; compare width covers the 7-bit limit too
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned MW = (CW > LIMIT_W) ? CW : LIMIT_W;

    // control registers
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic               out_valid_reg;

    // result payload registers
    status_t            status_reg;
    status_t            status_next;
    logic signed [31:0] rm_value_reg;
    logic signed [31:0] rm_value_next;
    logic signed [31:0] rm_pri_reg;
    logic signed [31:0] rm_pri_next;
    logic [OCC_W-1:0]   occ_reg;

    logic      accept;
    logic      full;
    logic      empty;
    logic      do_enq;
    logic      do_deq;
    cell_ctl_t ctl;

    entry_t                cell_entry [CAPACITY];
    logic [CAPACITY-1:0]   cell_keep;

    // output register frees up when its item is taken in the same edge
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // limit above CAPACITY saturates through the second compare
    assign full  = (MW'(count_reg) >= MW'(limit_reg)) || (count_reg >= CW'(CAPACITY));
    assign empty = (count_reg == '0);

    assign do_enq = accept && (op_t'(func) == OP_ENQ) && !full;
    assign do_deq = accept && (op_t'(func) == OP_DEQ) && !empty;

    assign ctl.load          = do_enq || do_deq;
    assign ctl.enq           = (op_t'(func) == OP_ENQ);
    assign ctl.new_entry.pri = priority_req;
    assign ctl.new_entry.val = value;

    // the cell chain, front of the queue at index 0
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_k;

            if (gi == 0)
            begin : g_head
                // nothing ahead of the front slot, so a new item lands here
                assign left_e = '0;
                assign left_k = 1'b1;
            end
            else
            begin : g_body
                assign left_e = cell_entry[gi-1];
                assign left_k = cell_keep[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_mid
                assign right_e = cell_entry[gi+1];
            end

            spaq_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (CW'(gi) < count_reg),
                .left_keep   (left_k),
                .left_entry  (left_e),
                .right_entry (right_e),
                .keep        (cell_keep[gi]),
                .entry       (cell_entry[gi])
            );
        end
    endgenerate

    // next count
    always_comb
    begin
        if (do_enq)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_deq)
        begin
            count_next = count_reg - CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // result fields, front entry goes out on a good dequeue
    always_comb
    begin
        status_next   = ST_DONE;
        rm_value_next = '0;
        rm_pri_next   = '0;
        if (op_t'(func) == OP_ENQ)
        begin
            if (full)
            begin
                status_next = ST_OVERFLOW;
            end
        end
        else if (empty)
        begin
            status_next = ST_UNDERFLOW;
        end
        else
        begin
            rm_value_next = cell_entry[0].val;
            rm_pri_next   = cell_entry[0].pri;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            rm_value_reg <= rm_value_next;
            rm_pri_reg   <= rm_pri_next;
            occ_reg      <= OCC_W'(count_next);
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign removed_value    = rm_value_reg;
    assign removed_priority = rm_pri_reg;
    assign occupancy        = occ_reg;

endmodule

`default_nettype wire

// ===== design/spaq_checker.sv =====
// spaq_checker: port-level checks on the priority queue top level, and its bind
// uses spaq_pkg; attaches to sorted_array_priority_queue_top
`timescale 1ns / 1ps
`default_nettype none

module spaq_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [1:0]         status,
    input  wire logic signed [31:0] removed_value,
    input  wire logic signed [31:0] removed_priority,
    input  wire logic [6:0]         occupancy
);
    import spaq_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(occupancy))
        else $error("result changed while stalled");

    // every taken item shows a result the next cycle
    a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item gave no result");

    // input stalls only behind a stalled result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

    // refused operations return zero fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OVERFLOW || status == ST_UNDERFLOW)
            |-> removed_value == 32'sd0 && removed_priority == 32'sd0)
        else $error("refused item carried data");

    // underflow only on an empty queue
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_UNDERFLOW |-> occupancy == 7'd0)
        else $error("underflow with entries held");

endmodule

bind sorted_array_priority_queue_top spaq_checker u_spaq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .removed_value    (removed_value),
    .removed_priority (removed_priority),
    .occupancy        (occupancy)
);

`default_nettype wire
